FILE: hw/rtl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types, constants and helper functions of the CAN bit timing
// calculator: preset table, quanta limits, controller/datapath interface.
// ----------------------------------------------------------------------------
package cbt_pkg;

   localparam int ClkW      = 27;
   localparam int RateW     = 20;
   localparam int PreW      = 24;
   localparam int Seg1W     = 4;
   localparam int Seg2W     = 3;
   localparam int QW        = 5;
   localparam int HowW      = 2;
   localparam int DivW      = QW + RateW;
   localparam int DivSteps  = ClkW;
   localparam int CntW      = $clog2(DivSteps);
   localparam int PresetNum = 8;
   localparam int PresetIdxW = $clog2(PresetNum);

   localparam logic [PreW-1:0]  PrescalerMax = {PreW{1'b1}};
   localparam logic [RateW-1:0] HighRate     = 20'd500000;
   localparam logic [QW-1:0]    TopQHigh     = 5'd18;
   localparam logic [QW-1:0]    TopQLow      = 5'd16;
   localparam logic [QW-1:0]    MinQ         = 5'd8;
   localparam logic [Seg1W-1:0] FbSeg1High   = 4'd14;
   localparam logic [Seg1W-1:0] FbSeg1Low    = 4'd12;
   localparam logic [Seg2W-1:0] FbSeg2       = 3'd3;

   localparam logic [ClkW-1:0] PresetClk [PresetNum] = '{
      27'd36000000, 27'd32000000, 27'd18000000, 27'd8000000,
      27'd36000000, 27'd32000000, 27'd18000000, 27'd8000000
   };
   localparam logic [RateW-1:0] PresetRate [PresetNum] = '{
      20'd500000, 20'd500000, 20'd500000, 20'd500000,
      20'd250000, 20'd250000, 20'd250000, 20'd250000
   };
   localparam logic [PreW-1:0] PresetPre [PresetNum] = '{
      24'd4, 24'd4, 24'd2, 24'd1, 24'd9, 24'd8, 24'd4, 24'd2
   };
   localparam logic [Seg1W-1:0] PresetSeg1 [PresetNum] = '{
      4'd14, 4'd12, 4'd14, 4'd12, 4'd12, 4'd12, 4'd13, 4'd12
   };
   localparam logic [Seg2W-1:0] PresetSeg2 [PresetNum] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3
   };

   typedef enum logic [HowW-1:0] {
      HOW_PRESET = 2'd0,
      HOW_EXACT  = 2'd1,
      HOW_APPROX = 2'd2
   } how_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic    load;
      logic    check;
      logic    div_start;
      logic    div_step;
      logic    save_fb;
      logic    dec_q;
      logic    set_how;
      how_type how;
      logic    write_out;
   } cmd_type;

   typedef struct packed {
      logic preset_hit;
      logic rate_zero;
      logic div_last;
      logic rem_zero;
      logic q_is_min;
      logic q_is_top;
      logic out_blocked;
   } status_type;

   typedef struct packed {
      logic                  hit;
      logic [PresetIdxW-1:0] idx;
   } preset_type;

   function automatic preset_type preset_lookup(input logic [ClkW-1:0]  clk,
                                                input logic [RateW-1:0] rate);
      preset_type res;
      res.hit = 1'b0;
      res.idx = '0;
      for (int i = PresetNum - 1; i >= 0; i--) begin
         if (PresetClk[i] == clk && PresetRate[i] == rate) begin
            res.hit = 1'b1;
            res.idx = PresetIdxW'(i);
         end
      end
      return res;
   endfunction

   function automatic logic [QW-1:0] top_quanta(input logic [RateW-1:0] rate);
      return (rate >= HighRate) ? TopQHigh : TopQLow;
   endfunction

   // q / 5 over the legal range of q
   function automatic logic [Seg2W-1:0] seg2_of(input logic [QW-1:0] q);
      logic [Seg2W-1:0] s2;
      case (q)
         5'd8, 5'd9:                       s2 = 3'd1;
         5'd10, 5'd11, 5'd12, 5'd13, 5'd14: s2 = 3'd2;
         5'd15, 5'd16, 5'd17, 5'd18, 5'd19: s2 = 3'd3;
         default:                          s2 = 3'd1;
      endcase
      return s2;
   endfunction

   function automatic logic [PreW-1:0] fit_prescaler(input logic [ClkW-1:0] p);
      logic [PreW-1:0] res;
      if (p == '0) begin
         res = PreW'(1);
      end else if (p > ClkW'(PrescalerMax)) begin
         res = PrescalerMax;
      end else begin
         res = p[PreW-1:0];
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/cbt_ctrl.sv
// ----------------------------------------------------------------------------
// cbt_ctrl
// Sequencer: preset check, divisor trials from the top quanta count down,
// result selection and hand-off to the output register.
// ----------------------------------------------------------------------------
module cbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cbt_pkg::status_type status,
   output cbt_pkg::cmd_type    cmd
);

   cbt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbt_pkg::ST_IDLE: begin
            if (req_valid) state_in = cbt_pkg::ST_CHECK;
         end
         cbt_pkg::ST_CHECK: begin
            if (status.preset_hit || status.rate_zero) begin
               state_in = cbt_pkg::ST_FINISH;
            end else begin
               state_in = cbt_pkg::ST_DIV_START;
            end
         end
         cbt_pkg::ST_DIV_START: begin
            state_in = cbt_pkg::ST_DIV_RUN;
         end
         cbt_pkg::ST_DIV_RUN: begin
            if (status.div_last) state_in = cbt_pkg::ST_EVAL;
         end
         cbt_pkg::ST_EVAL: begin
            if (status.rem_zero || status.q_is_min) begin
               state_in = cbt_pkg::ST_FINISH;
            end else begin
               state_in = cbt_pkg::ST_DIV_START;
            end
         end
         cbt_pkg::ST_FINISH: begin
            if (!status.out_blocked) state_in = cbt_pkg::ST_IDLE;
         end
         default: state_in = cbt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.how   = cbt_pkg::HOW_PRESET;
      req_ready = 1'b0;
      case (state_ff)
         cbt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         cbt_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.preset_hit) begin
               cmd.set_how = 1'b1;
               cmd.how     = cbt_pkg::HOW_PRESET;
            end else if (status.rate_zero) begin
               cmd.set_how = 1'b1;
               cmd.how     = cbt_pkg::HOW_APPROX;
            end
         end
         cbt_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         cbt_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
         end
         cbt_pkg::ST_EVAL: begin
            // first trial divides by top * rate: keep it for the fallback
            cmd.save_fb = status.q_is_top;
            if (status.rem_zero) begin
               cmd.set_how = 1'b1;
               cmd.how     = cbt_pkg::HOW_EXACT;
            end else if (status.q_is_min) begin
               cmd.set_how = 1'b1;
               cmd.how     = cbt_pkg::HOW_APPROX;
            end else begin
               cmd.dec_q = 1'b1;
            end
         end
         cbt_pkg::ST_FINISH: begin
            cmd.write_out = !status.out_blocked;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbt_pkg::ST_IDLE && req_valid) |=> state_ff == cbt_pkg::ST_CHECK)
      else $error("accepted item did not start a check");

   a_div_to_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbt_pkg::ST_DIV_RUN && status.div_last) |=>
         state_ff == cbt_pkg::ST_EVAL)
      else $error("division end did not lead to evaluation");

endmodule

FILE: hw/rtl/cbt_datapath.sv
// ----------------------------------------------------------------------------
// cbt_datapath
// Operand registers, quanta counter, divisor multiply, restoring divider
// (one quotient bit per cycle) and the result output register.
// ----------------------------------------------------------------------------
module cbt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  cbt_pkg::cmd_type                cmd,
   output cbt_pkg::status_type             status,
   input  logic [cbt_pkg::ClkW-1:0]        req_clock_hz,
   input  logic [cbt_pkg::RateW-1:0]       req_bit_rate,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cbt_pkg::PreW-1:0]        rsp_prescaler,
   output logic [cbt_pkg::Seg1W-1:0]       rsp_phase_seg1,
   output logic [cbt_pkg::Seg2W-1:0]       rsp_phase_seg2,
   output logic [cbt_pkg::QW-1:0]          rsp_total_quanta,
   output logic [cbt_pkg::HowW-1:0]        rsp_how_found
);

   logic [cbt_pkg::ClkW-1:0]  clk_ff;
   logic [cbt_pkg::RateW-1:0] rate_ff;
   logic [cbt_pkg::QW-1:0]    q_ff, q_in;
   logic [cbt_pkg::DivW-1:0]  div_ff;
   logic [cbt_pkg::DivW-1:0]  rem_ff, rem_in;
   logic [cbt_pkg::ClkW-1:0]  quot_ff, quot_in;
   logic [cbt_pkg::CntW-1:0]  cnt_ff, cnt_in;
   logic [cbt_pkg::PreW-1:0]  fb_pre_ff, fb_pre_in;
   cbt_pkg::how_type          how_ff;

   logic                      out_valid_ff;
   logic [cbt_pkg::PreW-1:0]  out_pre_ff, out_pre_in;
   logic [cbt_pkg::Seg1W-1:0] out_seg1_ff, out_seg1_in;
   logic [cbt_pkg::Seg2W-1:0] out_seg2_ff, out_seg2_in;
   logic [cbt_pkg::QW-1:0]    out_total_ff, out_total_in;
   logic [cbt_pkg::HowW-1:0]  out_how_ff;

   cbt_pkg::preset_type       preset;
   logic [cbt_pkg::QW-1:0]    top_q;
   logic [cbt_pkg::DivW-1:0]  product;
   logic [cbt_pkg::DivW:0]    rem_sh;
   logic                      ge;
   logic [cbt_pkg::Seg2W-1:0] exact_seg2;

   assign preset = cbt_pkg::preset_lookup(clk_ff, rate_ff);
   assign top_q  = cbt_pkg::top_quanta(rate_ff);
   assign product = cbt_pkg::DivW'(q_ff) * cbt_pkg::DivW'(rate_ff);

   // restoring divider step: shift in the next dividend bit, try to subtract
   assign rem_sh = {rem_ff, quot_ff[cbt_pkg::ClkW-1]};
   assign ge     = rem_sh >= {1'b0, div_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      fb_pre_in = fb_pre_ff;
      if (cmd.check) begin
         q_in = top_q;
         if (rate_ff == '0) fb_pre_in = cbt_pkg::PrescalerMax;
      end
      if (cmd.dec_q) q_in = q_ff - cbt_pkg::QW'(1);
      if (cmd.div_start) begin
         rem_in  = '0;
         quot_in = clk_ff;
         cnt_in  = cbt_pkg::CntW'(cbt_pkg::DivSteps - 1);
      end
      if (cmd.div_step) begin
         rem_in  = ge ? cbt_pkg::DivW'(rem_sh - {1'b0, div_ff})
                      : rem_sh[cbt_pkg::DivW-1:0];
         quot_in = {quot_ff[cbt_pkg::ClkW-2:0], ge};
         cnt_in  = cnt_ff - cbt_pkg::CntW'(1);
      end
      if (cmd.save_fb) fb_pre_in = cbt_pkg::fit_prescaler(quot_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         clk_ff  <= req_clock_hz;
         rate_ff <= req_bit_rate;
      end
      if (cmd.div_start) div_ff <= product;
      if (cmd.set_how) how_ff <= cmd.how;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      cnt_ff    <= cnt_in;
      fb_pre_ff <= fb_pre_in;
   end

   assign exact_seg2 = cbt_pkg::seg2_of(q_ff);

   always_comb begin
      case (how_ff)
         cbt_pkg::HOW_PRESET: begin
            out_pre_in   = cbt_pkg::PresetPre[preset.idx];
            out_seg1_in  = cbt_pkg::PresetSeg1[preset.idx];
            out_seg2_in  = cbt_pkg::PresetSeg2[preset.idx];
            out_total_in = cbt_pkg::QW'(1) + cbt_pkg::QW'(out_seg1_in)
                           + cbt_pkg::QW'(out_seg2_in);
         end
         cbt_pkg::HOW_EXACT: begin
            out_pre_in   = cbt_pkg::fit_prescaler(quot_ff);
            out_seg2_in  = exact_seg2;
            out_seg1_in  = cbt_pkg::Seg1W'(q_ff - cbt_pkg::QW'(1)
                                           - cbt_pkg::QW'(exact_seg2));
            out_total_in = q_ff;
         end
         default: begin
            out_pre_in   = fb_pre_ff;
            out_seg1_in  = (top_q == cbt_pkg::TopQHigh) ? cbt_pkg::FbSeg1High
                                                          : cbt_pkg::FbSeg1Low;
            out_seg2_in  = cbt_pkg::FbSeg2;
            out_total_in = top_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.write_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_out) begin
         out_pre_ff   <= out_pre_in;
         out_seg1_ff  <= out_seg1_in;
         out_seg2_ff  <= out_seg2_in;
         out_total_ff <= out_total_in;
         out_how_ff   <= how_ff;
      end
   end

   assign status.preset_hit  = preset.hit;
   assign status.rate_zero   = (rate_ff == '0);
   assign status.div_last    = (cnt_ff == '0);
   assign status.rem_zero    = (rem_ff == '0);
   assign status.q_is_min    = (q_ff == cbt_pkg::MinQ);
   assign status.q_is_top    = (q_ff == top_q);
   assign status.out_blocked = out_valid_ff && !rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_prescaler    = out_pre_ff;
   assign rsp_phase_seg1   = out_seg1_ff;
   assign rsp_phase_seg2   = out_seg2_ff;
   assign rsp_total_quanta = out_total_ff;
   assign rsp_how_found    = out_how_ff;

   a_dec_above_min: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_q |-> q_ff > cbt_pkg::MinQ)
      else $error("quanta count stepped below the minimum");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |-> (!out_valid_ff || rsp_ready))
      else $error("pending result overwritten");

endmodule

FILE: hw/rtl/can_bit_timing_calc_unit.sv
// Sequence: a preset or zero-bitrate item goes from the check straight to the output
// register; any other item runs divisor trials (start, 27 divide steps, evaluate), at
// most 11 trials. One item at a time: the next item is accepted only once the previous
// result has moved into the output register.
// Reset clears the sequencer and the output valid flag; nothing else is cleared.
// ----------------------------------------------------------------------------
// can_bit_timing_calc_unit
// CAN bit timing calculator: prescaler and phase segments from a peripheral
// clock and a bitrate, by preset table, exact divisor search or fallback.
// ----------------------------------------------------------------------------
module can_bit_timing_calc_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cbt_pkg::ClkW-1:0]   req_clock_hz,
   input  logic [cbt_pkg::RateW-1:0]  req_bit_rate,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cbt_pkg::PreW-1:0]   rsp_prescaler,
   output logic [cbt_pkg::Seg1W-1:0]  rsp_phase_seg1,
   output logic [cbt_pkg::Seg2W-1:0]  rsp_phase_seg2,
   output logic [cbt_pkg::QW-1:0]     rsp_total_quanta,
   output logic [cbt_pkg::HowW-1:0]   rsp_how_found
);

   cbt_pkg::cmd_type    cmd;
   cbt_pkg::status_type status;

   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_clock_hz     (req_clock_hz),
      .req_bit_rate     (req_bit_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prescaler    (rsp_prescaler),
      .rsp_phase_seg1   (rsp_phase_seg1),
      .rsp_phase_seg2   (rsp_phase_seg2),
      .rsp_total_quanta (rsp_total_quanta),
      .rsp_how_found    (rsp_how_found)
   );

endmodule

FILE: bench/can_bit_timing_calc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_bit_timing_calc_checker
// Watches the request and result channels of the bit timing calculator.
// Predicts the timing of each accepted request and compares every result
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module can_bit_timing_calc_checker
   import cbt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [ClkW-1:0]   req_clock_hz,
   input  logic [RateW-1:0]  req_bit_rate,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [PreW-1:0]   rsp_prescaler,
   input  logic [Seg1W-1:0]  rsp_phase_seg1,
   input  logic [Seg2W-1:0]  rsp_phase_seg2,
   input  logic [QW-1:0]     rsp_total_quanta,
   input  logic [HowW-1:0]   rsp_how_found,
   output int unsigned       fail_count,
   output int unsigned       pending
);

   typedef struct packed {
      logic [PreW-1:0]  prescaler;
      logic [Seg1W-1:0] seg1;
      logic [Seg2W-1:0] seg2;
      logic [QW-1:0]    quanta;
      how_type          how;
   } bit_timing_type;

   bit_timing_type timing_q [$];

   function automatic logic [PreW-1:0] clamp_prescaler(input longint unsigned p);
      if (p == 0) return PreW'(1);
      if (p > longint'(PrescalerMax)) return PrescalerMax;
      return p[PreW-1:0];
   endfunction

   function automatic bit_timing_type calc_timing(input logic [ClkW-1:0]  clk_hz,
                                                  input logic [RateW-1:0] rate);
      bit_timing_type res;
      longint unsigned clk64;
      longint unsigned divisor;
      int top;
      int s2;
      logic hit;
      hit = 1'b0;
      clk64 = clk_hz;
      res = '0;
      case ({clk_hz, rate})
         {27'd36000000, 20'd500000}: begin
            res.prescaler = 24'd4; res.seg1 = 4'd14; res.seg2 = 3'd3; hit = 1'b1;
         end
         {27'd32000000, 20'd500000}: begin
            res.prescaler = 24'd4; res.seg1 = 4'd12; res.seg2 = 3'd3; hit = 1'b1;
         end
         {27'd18000000, 20'd500000}: begin
            res.prescaler = 24'd2; res.seg1 = 4'd14; res.seg2 = 3'd3; hit = 1'b1;
         end
         {27'd8000000, 20'd500000}: begin
            res.prescaler = 24'd1; res.seg1 = 4'd12; res.seg2 = 3'd3; hit = 1'b1;
         end
         {27'd36000000, 20'd250000}: begin
            res.prescaler = 24'd9; res.seg1 = 4'd12; res.seg2 = 3'd3; hit = 1'b1;
         end
         {27'd32000000, 20'd250000}: begin
            res.prescaler = 24'd8; res.seg1 = 4'd12; res.seg2 = 3'd3; hit = 1'b1;
         end
         {27'd18000000, 20'd250000}: begin
            res.prescaler = 24'd4; res.seg1 = 4'd13; res.seg2 = 3'd4; hit = 1'b1;
         end
         {27'd8000000, 20'd250000}: begin
            res.prescaler = 24'd2; res.seg1 = 4'd12; res.seg2 = 3'd3; hit = 1'b1;
         end
         default: ;
      endcase
      if (hit) begin
         res.quanta = 5'd1 + res.seg1 + res.seg2;
         res.how = HOW_PRESET;
         return res;
      end
      top = (rate >= HighRate) ? 18 : 16;
      res.quanta = QW'(top);
      res.seg1 = (top == 18) ? FbSeg1High : FbSeg1Low;
      res.seg2 = FbSeg2;
      res.how = HOW_APPROX;
      // no divisor exists for a zero bitrate
      if (rate == 0) begin
         res.prescaler = PrescalerMax;
         return res;
      end
      for (int q = top; q >= 8; q--) begin
         divisor = longint'(q) * rate;
         if (clk64 % divisor == 0) begin
            s2 = (q / 5 < 1) ? 1 : q / 5;
            res.prescaler = clamp_prescaler(clk64 / divisor);
            res.seg2 = Seg2W'(s2);
            res.seg1 = Seg1W'(q - 1 - s2);
            res.quanta = QW'(q);
            res.how = HOW_EXACT;
            return res;
         end
      end
      res.prescaler = clamp_prescaler(clk64 / (longint'(top) * rate));
      return res;
   endfunction

   function automatic int field_bad(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      bit_timing_type want;
      int errs;
      errs = 0;
      if (reset) begin
         timing_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         // retire the oldest prediction before queuing a new one
         if (rsp_valid && rsp_ready) begin
            if (timing_q.size() == 0) begin
               $error("result item with no request waiting: prescaler %0d", rsp_prescaler);
               errs++;
            end else begin
               want = timing_q.pop_front();
               errs += field_bad("prescaler", 32'(want.prescaler), 32'(rsp_prescaler));
               errs += field_bad("phase_seg1", 32'(want.seg1), 32'(rsp_phase_seg1));
               errs += field_bad("phase_seg2", 32'(want.seg2), 32'(rsp_phase_seg2));
               errs += field_bad("total_quanta", 32'(want.quanta),
                                 32'(rsp_total_quanta));
               errs += field_bad("how_found", 32'(want.how), 32'(rsp_how_found));
            end
         end
         if (req_valid && req_ready) begin
            timing_q.push_back(calc_timing(req_clock_hz, req_bit_rate));
         end
         fail_count <= fail_count + errs;
         pending <= timing_q.size();
      end
   end

endmodule

FILE: bench/tb_can_bit_timing_calc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_bit_timing_calc_unit
// Drives clock/bitrate requests into the bit timing calculator: directed
// corner items, then random items under several idle and stall mixes and one
// long result hold-off. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_can_bit_timing_calc_unit;
   import cbt_pkg::*;

   localparam int HalfPeriod     = 6;
   localparam int ResetCycles    = 7;
   localparam int RandomPerPhase = 300;
   localparam int HoldCycles     = 1000;
   localparam int DrainCycles    = 400;
   localparam int WatchdogLimit  = 5000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [ClkW-1:0]   req_clock_hz = '0;
   logic [RateW-1:0]  req_bit_rate = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [PreW-1:0]   rsp_prescaler;
   logic [Seg1W-1:0]  rsp_phase_seg1;
   logic [Seg2W-1:0]  rsp_phase_seg2;
   logic [QW-1:0]     rsp_total_quanta;
   logic [HowW-1:0]   rsp_how_found;

   int unsigned fail_count;
   int unsigned pending;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_count = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic        req_fire = 1'b0;

   always #HalfPeriod clock = ~clock;

   can_bit_timing_calc_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_clock_hz     (req_clock_hz),
      .req_bit_rate     (req_bit_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prescaler    (rsp_prescaler),
      .rsp_phase_seg1   (rsp_phase_seg1),
      .rsp_phase_seg2   (rsp_phase_seg2),
      .rsp_total_quanta (rsp_total_quanta),
      .rsp_how_found    (rsp_how_found)
   );

   can_bit_timing_calc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_clock_hz     (req_clock_hz),
      .req_bit_rate     (req_bit_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prescaler    (rsp_prescaler),
      .rsp_phase_seg1   (rsp_phase_seg1),
      .rsp_phase_seg2   (rsp_phase_seg2),
      .rsp_total_quanta (rsp_total_quanta),
      .rsp_how_found    (rsp_how_found),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // capture acceptance at the edge so the sender can read it at the falling edge
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_count) begin
         rsp_ready <= 1'b0;
         hold_served <= hold_count;
         hold_left <= HoldCycles;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [RateW-1:0] random_rate();
      case ($urandom_range(3))
         0:       return RateW'($urandom_range(1000000, 500000));
         1:       return RateW'($urandom_range(499999, 1));
         2:       return RateW'($urandom_range((1 << RateW) - 1, 1000001));
         default: return RateW'($urandom) >> $urandom_range(RateW - 1);
      endcase
   endfunction

   task automatic send_item(input logic [ClkW-1:0] clk_hz, input logic [RateW-1:0] rate);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_clock_hz <= clk_hz;
      req_bit_rate <= rate;
      do @(negedge clock); while (!req_fire);
   endtask

   initial begin
      logic [ClkW-1:0]  clk_hz;
      logic [RateW-1:0] rate;
      int unsigned      q;
      int unsigned      pre_max;
      int unsigned      kind;
      int unsigned      idx;

      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;

      // presets
      send_item(27'd36000000, 20'd500000);
      send_item(27'd32000000, 20'd500000);
      send_item(27'd18000000, 20'd500000);
      send_item(27'd8000000, 20'd500000);
      send_item(27'd36000000, 20'd250000);
      send_item(27'd32000000, 20'd250000);
      send_item(27'd18000000, 20'd250000);
      send_item(27'd8000000, 20'd250000);
      // near misses of the table
      send_item(27'd36000000, 20'd125000);
      send_item(27'd36000000, 20'd1000000);
      send_item(27'd9000000, 20'd500000);
      send_item(27'd8000000, 20'd499999);
      // zero bitrate and zero clock
      send_item(27'd12345678, 20'd0);
      send_item(27'd0, 20'd0);
      send_item(27'd0, 20'd500000);
      send_item(27'd0, 20'd1);
      // smallest quanta counts and fallbacks
      send_item(27'd8, 20'd1);
      send_item(27'd9, 20'd1);
      send_item(27'd10, 20'd1);
      send_item(27'd1, 20'd1);
      send_item(27'd1000001, 20'd500000);
      send_item({ClkW{1'b1}}, 20'd1);
      send_item({ClkW{1'b1}}, {RateW{1'b1}});

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  hold_count++; end
            1: begin send_idle_pct = 53; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         for (int n = 0; n < RandomPerPhase; n++) begin
            kind = $urandom_range(99);
            if (kind < 12) begin
               // table entry, now and then with one bit flipped
               idx = $urandom_range(7);
               case (idx % 4)
                  0: clk_hz = 27'd36000000;
                  1: clk_hz = 27'd32000000;
                  2: clk_hz = 27'd18000000;
                  default: clk_hz = 27'd8000000;
               endcase
               rate = (idx < 4) ? 20'd500000 : 20'd250000;
               if ($urandom_range(2) == 0) begin
                  if ($urandom_range(1) == 1) clk_hz[$urandom_range(ClkW - 1)] ^= 1'b1;
                  else rate[$urandom_range(RateW - 1)] ^= 1'b1;
               end
            end else if (kind < 55) begin
               // clock built as an exact multiple of q * bitrate
               q = $urandom_range(18, 8);
               rate = random_rate();
               if (rate == '0) rate = 20'd1;
               pre_max = ((1 << ClkW) - 1) / (q * rate);
               clk_hz = ClkW'($urandom_range(pre_max, 1) * q * rate);
            end else if (kind < 63) begin
               clk_hz = ClkW'($urandom);
               rate = random_rate();
               case ($urandom_range(3))
                  0: rate = '0;
                  1: clk_hz = '0;
                  2: clk_hz = '1;
                  default: rate = '1;
               endcase
            end else begin
               clk_hz = ClkW'($urandom);
               rate = random_rate();
            end
            send_item(clk_hz, rate);
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
